@@ rtl/cmd_pkg.sv @@
// cmd_pkg: request types and shared constants of the cell motion detector
// no dependencies; used by cmd_accum, cmd_stat and cell_motion_detector_core
package cmd_pkg;

  localparam int PIX_W        = 8;
  localparam int IDX_W        = 8;
  localparam int THRESH_W     = 12;
  localparam int VAR_W        = 30;
  localparam int CELL_SIDE_DEF = 16;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 12'd128;
  localparam logic [VAR_W-1:0]    VAR_MAX      = {VAR_W{1'b1}};

  typedef struct packed {
    logic [PIX_W-1:0] previous_pixel;
    logic [PIX_W-1:0] current_pixel;
    logic [IDX_W-1:0] cell_column;
    logic [IDX_W-1:0] cell_row;
    logic             end_of_cell;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] out_column;
    logic [IDX_W-1:0] out_row;
    logic             motion;
    logic [VAR_W-1:0] scaled_variance;
  } out_item_t;

endpackage

@@ rtl/cmd_accum.sv @@
// cmd_accum: input register, running sums of |difference| and its square,
// and the per-cell snapshot register; depends on cmd_pkg
module cmd_accum #(
  parameter int CELL_SIDE = cmd_pkg::CELL_SIDE_DEF,
  parameter int CNT_W     = $clog2(CELL_SIDE * CELL_SIDE + 1),
  parameter int SUM_W     = cmd_pkg::PIX_W + CNT_W,
  parameter int SQ_W      = 2 * cmd_pkg::PIX_W + CNT_W
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  cmd_pkg::in_item_t        in_data,
  output logic                     snap_valid,
  input  logic                     snap_ready,
  output logic [CNT_W-1:0]         snap_n,
  output logic [SUM_W-1:0]         snap_sum,
  output logic [SQ_W-1:0]          snap_sq,
  output logic [cmd_pkg::IDX_W-1:0] snap_column,
  output logic [cmd_pkg::IDX_W-1:0] snap_row
);

  localparam int PAIRS = CELL_SIDE * CELL_SIDE;

  logic                         s0_valid_r;
  cmd_pkg::in_item_t            s0_item_r;
  logic                         s0_go;
  logic                         s0_load;
  logic                         s1_valid_r;
  logic                         s1_free;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic [SUM_W-1:0]             sum_r, sum_nxt;
  logic [SQ_W-1:0]              sq_r, sq_nxt;
  logic [cmd_pkg::PIX_W-1:0]    diff;
  logic [2*cmd_pkg::PIX_W-1:0]  diff_sq;
  logic                         take;
  logic [CNT_W-1:0]             n_r;
  logic [SUM_W-1:0]             snap_sum_r;
  logic [SQ_W-1:0]              snap_sq_r;
  logic [cmd_pkg::IDX_W-1:0]    col_r, row_r;

  assign s1_free  = !s1_valid_r || snap_ready;
  assign s0_go    = s0_valid_r && (!s0_item_r.end_of_cell || s1_free);
  assign in_stall = s0_valid_r && !s0_go;
  assign s0_load  = in_valid && !in_stall;

  // absolute difference, its square and the next running sums
  always_comb begin
    if (s0_item_r.current_pixel >= s0_item_r.previous_pixel) begin
      diff = s0_item_r.current_pixel - s0_item_r.previous_pixel;
    end else begin
      diff = s0_item_r.previous_pixel - s0_item_r.current_pixel;
    end
    diff_sq = diff * diff;
    take    = cnt_r < CNT_W'(PAIRS);
    if (take) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      sum_nxt = sum_r + SUM_W'(diff);
      sq_nxt  = sq_r + SQ_W'(diff_sq);
    end else begin
      cnt_nxt = cnt_r;
      sum_nxt = sum_r;
      sq_nxt  = sq_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (!s0_valid_r || s0_go) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_load) begin
      s0_item_r <= in_data;
    end
  end

  // running sums, cleared when a cell closes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sum_r <= '0;
      sq_r  <= '0;
    end else if (s0_go) begin
      if (s0_item_r.end_of_cell) begin
        cnt_r <= '0;
        sum_r <= '0;
        sq_r  <= '0;
      end else begin
        cnt_r <= cnt_nxt;
        sum_r <= sum_nxt;
        sq_r  <= sq_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s0_go && s0_item_r.end_of_cell) begin
      s1_valid_r <= 1'b1;
    end else if (snap_ready) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_go && s0_item_r.end_of_cell) begin
      n_r        <= cnt_nxt;
      snap_sum_r <= sum_nxt;
      snap_sq_r  <= sq_nxt;
      col_r      <= s0_item_r.cell_column;
      row_r      <= s0_item_r.cell_row;
    end
  end

  assign snap_valid  = s1_valid_r;
  assign snap_n      = n_r;
  assign snap_sum    = snap_sum_r;
  assign snap_sq     = snap_sq_r;
  assign snap_column = col_r;
  assign snap_row    = row_r;

  // pair count never passes the cell size
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(PAIRS))
    else $error("pair count beyond cell size");

  // a closing pair leaves cleared sums behind
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_go && s0_item_r.end_of_cell) |=> (cnt_r == '0 && sum_r == '0 && sq_r == '0))
    else $error("sums not cleared after cell");

  // a snapshot always counts at least one pair
  a_snap_n: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (n_r != '0))
    else $error("empty cell snapshot");

endmodule

@@ rtl/cmd_stat.sv @@
// cmd_stat: product and variance stages plus threshold compare into the result register
// depends on cmd_pkg; fed by the snapshot of cmd_accum
module cmd_stat #(
  parameter int CELL_SIDE = cmd_pkg::CELL_SIDE_DEF,
  parameter int CNT_W     = $clog2(CELL_SIDE * CELL_SIDE + 1),
  parameter int SUM_W     = cmd_pkg::PIX_W + CNT_W,
  parameter int SQ_W      = 2 * cmd_pkg::PIX_W + CNT_W
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         snap_valid,
  output logic                         snap_ready,
  input  logic [CNT_W-1:0]             snap_n,
  input  logic [SUM_W-1:0]             snap_sum,
  input  logic [SQ_W-1:0]              snap_sq,
  input  logic [cmd_pkg::IDX_W-1:0]    snap_column,
  input  logic [cmd_pkg::IDX_W-1:0]    snap_row,
  input  logic [cmd_pkg::THRESH_W-1:0] threshold,
  output logic                         out_valid,
  input  logic                         out_stall,
  output cmd_pkg::out_item_t           out_data
);

  localparam int P1_W  = CNT_W + SQ_W;
  localparam int P2_W  = 2 * SUM_W;
  localparam int T2_W  = 2 * cmd_pkg::THRESH_W;
  localparam int N2_W  = 2 * CNT_W;
  localparam int RHS_W = T2_W + N2_W;
  localparam int LHS_W = P1_W + 8;
  localparam int CMP_W = (LHS_W > RHS_W) ? LHS_W : RHS_W;
  localparam int SAT_W = (P1_W > cmd_pkg::VAR_W) ? P1_W : cmd_pkg::VAR_W;

  logic                      v2_r, v3_r, v4_r;
  logic                      adv4, adv3, adv2;
  logic [P1_W-1:0]           p1, p1_r;
  logic [P2_W-1:0]           p2, p2_r;
  logic [T2_W-1:0]           t2, t2_r;
  logic [N2_W-1:0]           n2, n2_r;
  logic [P1_W-1:0]           scaled_r;
  logic [RHS_W-1:0]          rhs, rhs_r;
  logic [CMP_W-1:0]          lhs_ext, rhs_ext;
  logic [SAT_W-1:0]          scaled_ext;
  logic [cmd_pkg::IDX_W-1:0] col2_r, row2_r, col3_r, row3_r;
  cmd_pkg::out_item_t        res_nxt, res_r;

  assign adv4       = !v4_r || !out_stall;
  assign adv3       = !v3_r || adv4;
  assign adv2       = !v2_r || adv3;
  assign snap_ready = adv2;

  assign p1  = snap_n * snap_sq;
  assign p2  = snap_sum * snap_sum;
  assign t2  = threshold * threshold;
  assign n2  = snap_n * snap_n;
  assign rhs = t2_r * n2_r;

  always_comb begin
    lhs_ext    = CMP_W'({scaled_r, 8'd0});
    rhs_ext    = CMP_W'(rhs_r);
    scaled_ext = SAT_W'(scaled_r);
    res_nxt.out_column = col3_r;
    res_nxt.out_row    = row3_r;
    res_nxt.motion     = lhs_ext > rhs_ext;
    if (scaled_ext > SAT_W'(cmd_pkg::VAR_MAX)) begin
      res_nxt.scaled_variance = cmd_pkg::VAR_MAX;
    end else begin
      res_nxt.scaled_variance = cmd_pkg::VAR_W'(scaled_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (adv2) begin
        v2_r <= snap_valid;
      end
      if (adv3) begin
        v3_r <= v2_r;
      end
      if (adv4) begin
        v4_r <= v3_r;
      end
    end
  end

  // products
  always_ff @(posedge clk) begin
    if (adv2 && snap_valid) begin
      p1_r   <= p1;
      p2_r   <= p2;
      t2_r   <= t2;
      n2_r   <= n2;
      col2_r <= snap_column;
      row2_r <= snap_row;
    end
  end

  // scaled variance and squared threshold times n squared
  always_ff @(posedge clk) begin
    if (adv3 && v2_r) begin
      scaled_r <= p1_r - P1_W'(p2_r);
      rhs_r    <= rhs;
      col3_r   <= col2_r;
      row3_r   <= row2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv4 && v3_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_data  = res_r;

  // n times square sum never falls below sum squared
  a_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (p1_r >= P1_W'(p2_r)))
    else $error("negative scaled variance");

  // motion needs a nonzero spread
  a_motion: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && res_r.motion) |-> (res_r.scaled_variance != '0))
    else $error("motion flagged on zero variance");

  // a waiting result keeps the last stage from being overwritten
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && out_stall) |=> (v4_r && $stable(res_r)))
    else $error("stalled result lost");

endmodule

@@ rtl/cell_motion_detector_core.sv @@
// cell_motion_detector_core: top level, threshold register and the two datapath parts
// depends on cmd_pkg, cmd_accum and cmd_stat
//
//  channel | direction | handshake         | payload
//  in_     | input     | in_valid/in_stall | cmd_pkg::in_item_t, one pixel pair
//  out_    | output    | out_valid/out_stall | cmd_pkg::out_item_t, one per cell
//  cfg_    | input     | cfg_valid/cfg_ready | motion threshold, 12 bits
//
// one pixel pair taken per cycle unless in_stall is high; the edge that accepts a
// closing pair loads the input reg, then its result passes snapshot, products,
// variance and compare/result reg
// rst_n clears all valids and sums and sets the threshold to 8.0
// out_stall holds the full stages back to the snapshot; the input stalls only when a closing pair meets a full snapshot
module cell_motion_detector_core #(
  parameter int CELL_SIDE = cmd_pkg::CELL_SIDE_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  cmd_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output cmd_pkg::out_item_t           out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [cmd_pkg::THRESH_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(CELL_SIDE * CELL_SIDE + 1);
  localparam int SUM_W = cmd_pkg::PIX_W + CNT_W;
  localparam int SQ_W  = 2 * cmd_pkg::PIX_W + CNT_W;

  logic [cmd_pkg::THRESH_W-1:0] thresh_r;
  logic                         snap_valid;
  logic                         snap_ready;
  logic [CNT_W-1:0]             snap_n;
  logic [SUM_W-1:0]             snap_sum;
  logic [SQ_W-1:0]              snap_sq;
  logic [cmd_pkg::IDX_W-1:0]    snap_column;
  logic [cmd_pkg::IDX_W-1:0]    snap_row;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= cmd_pkg::THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thresh_r <= cfg_data;
    end
  end

  cmd_accum #(
    .CELL_SIDE (CELL_SIDE),
    .CNT_W     (CNT_W),
    .SUM_W     (SUM_W),
    .SQ_W      (SQ_W)
  ) u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .snap_valid  (snap_valid),
    .snap_ready  (snap_ready),
    .snap_n      (snap_n),
    .snap_sum    (snap_sum),
    .snap_sq     (snap_sq),
    .snap_column (snap_column),
    .snap_row    (snap_row)
  );

  cmd_stat #(
    .CELL_SIDE (CELL_SIDE),
    .CNT_W     (CNT_W),
    .SUM_W     (SUM_W),
    .SQ_W      (SQ_W)
  ) u_stat (
    .clk         (clk),
    .rst_n       (rst_n),
    .snap_valid  (snap_valid),
    .snap_ready  (snap_ready),
    .snap_n      (snap_n),
    .snap_sum    (snap_sum),
    .snap_sq     (snap_sq),
    .snap_column (snap_column),
    .snap_row    (snap_row),
    .threshold   (thresh_r),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
